// ----- hdl/mkd_pkg.sv -----
// Package for the Morse key decoder: event kind codes, register indexes
// and the fixed Morse lookup table. No dependencies.
`default_nettype none

package mkd_pkg;

  localparam int unsigned KindW = 3;
  localparam int unsigned CharW = 7;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DebW = 10;
  localparam int unsigned TimW = 16;

  typedef enum logic [KindW-1:0] {
    EV_DOT     = 3'd0,
    EV_DASH    = 3'd1,
    EV_CLEAR   = 3'd2,
    EV_CHAR    = 3'd3,
    EV_UNKNOWN = 3'd4
  } event_kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 8'd0,
    REG_DASH     = 8'd1,
    REG_LONG     = 8'd2,
    REG_GAP      = 8'd3
  } cfg_reg_t;

  // Codes of one to four symbols, indexed by (2^len - 2) + code with the
  // first symbol as the MSB of code and a dash as 1. Zero means unknown.
  localparam logic [CharW-1:0] MORSE_TABLE [30] = '{
    7'h65, 7'h74,
    7'h69, 7'h61, 7'h6e, 7'h6d,
    7'h73, 7'h75, 7'h72, 7'h77, 7'h64, 7'h6b, 7'h67, 7'h6f,
    7'h68, 7'h76, 7'h66, 7'h00, 7'h6c, 7'h2a, 7'h70, 7'h6a,
    7'h62, 7'h78, 7'h63, 7'h79, 7'h7a, 7'h71, 7'h00, 7'h00
  };

  localparam logic [CharW-1:0] CHAR_SPACE = 7'h20;
  localparam logic [4:0] SPACE_CODE = 5'd10;

  // seq[0] is the first symbol; len is 1 to 5. Returns 0 for unknown codes.
  function automatic logic [CharW-1:0] morse_lookup(input logic [4:0] seq,
                                                    input logic [2:0] len);
    logic [4:0] code;
    logic [4:0] idx;
    logic [CharW-1:0] ch;
    code = '0;
    for (int i = 0; i < 5; i++) begin
      if (3'(i) < len) begin
        code = {code[3:0], seq[i]};
      end
    end
    idx = (5'd1 << len) - 5'd2 + code;
    if (len == 3'd5) begin
      ch = (code == SPACE_CODE) ? CHAR_SPACE : '0;
    end else if (len == 3'd0 || len > 3'd5 || idx >= 5'd30) begin
      ch = '0;
    end else begin
      ch = MORSE_TABLE[idx];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/morse_key_decoder.sv -----
// Morse key decoder: one key sample per tick in, at most one event per tick out.
// Each event is registered: it appears in the cycle after the sample that causes it.
// Throughput: one sample per cycle while the output is taken; a held result
// stalls the input for as long as out_ready stays low.
// Reset (rst_n low, synchronous) restores register defaults and empties all state.
// Depends on mkd_pkg.
`default_nettype none

module morse_key_decoder #(
  parameter int unsigned MAX_SYMBOLS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_key_level,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mkd_pkg::KindW-1:0]          out_event_kind,
  output logic [mkd_pkg::CharW-1:0]          out_char_code,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mkd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [mkd_pkg::CfgDataW-1:0]  cfg_wdata
);
  import mkd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned IdxW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SYMBOLS);
  localparam logic [CntW-1:0] DecodeMax = CntW'(5);

  logic [DebW-1:0] debounce_r;
  logic [TimW-1:0] dash_thr_r, long_thr_r, gap_thr_r;

  logic                   raw_prev_r, raw_prev_nxt;
  logic [DebW-1:0]        stable_r, stable_nxt;
  logic                   deb_r, deb_nxt;
  logic [TimW-1:0]        press_r, press_nxt;
  logic [TimW-1:0]        gap_r, gap_nxt;
  logic [MAX_SYMBOLS-1:0] sym_r, sym_nxt;
  logic [CntW-1:0]        count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   gapdec_r, gapdec_nxt;

  logic                   out_valid_r, out_valid_nxt;
  event_kind_t            out_kind_r;
  logic [CharW-1:0]       out_char_r;

  logic                   in_fire, edge_det, sym_bit;
  logic                   res_valid;
  event_kind_t            res_kind;
  logic [CharW-1:0]       res_char, dec_char;
  logic [TimW-1:0]        gap_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_char_code  = out_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DebW'(50);
      dash_thr_r <= TimW'(150);
      long_thr_r <= TimW'(500);
      gap_thr_r  <= TimW'(1000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_r <= cfg_wdata[DebW-1:0];
        REG_DASH:     dash_thr_r <= cfg_wdata;
        REG_LONG:     long_thr_r <= cfg_wdata;
        REG_GAP:      gap_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The first five stored symbols feed the table; longer codes are unknown.
  always_comb begin
    if (ovf_r || count_r == '0 || count_r > DecodeMax) begin
      dec_char = '0;
    end else begin
      dec_char = morse_lookup({sym_r[4], sym_r[3], sym_r[2], sym_r[1], sym_r[0]},
                              count_r[2:0]);
    end
  end

  always_comb begin
    raw_prev_nxt = raw_prev_r;
    stable_nxt   = stable_r;
    deb_nxt      = deb_r;
    press_nxt    = press_r;
    gap_nxt      = gap_r;
    sym_nxt      = sym_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    gapdec_nxt   = gapdec_r;
    res_valid    = 1'b0;
    res_kind     = EV_DOT;
    res_char     = '0;
    edge_det     = 1'b0;
    sym_bit      = 1'b0;
    gap_inc      = (gap_r == '1) ? gap_r : gap_r + TimW'(1);

    if (in_fire) begin
      raw_prev_nxt = in_key_level;
      if (in_key_level != raw_prev_r) begin
        stable_nxt = '0;
      end else begin
        stable_nxt = (stable_r == '1) ? stable_r : stable_r + DebW'(1);
      end
      edge_det = (stable_nxt >= debounce_r) && (in_key_level != deb_r);

      if (edge_det) begin
        deb_nxt = in_key_level;
        if (in_key_level) begin
          press_nxt = '0;
        end else begin
          gap_nxt    = '0;
          gapdec_nxt = 1'b0;
          res_valid  = 1'b1;
          if (press_r > long_thr_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            res_kind  = EV_CLEAR;
          end else begin
            sym_bit = (press_r > dash_thr_r);
            if (count_r < MaxCnt) begin
              sym_nxt[count_r[IdxW-1:0]] = sym_bit;
              count_nxt = count_r + CntW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            res_kind = sym_bit ? EV_DASH : EV_DOT;
          end
        end
      end else if (deb_r) begin
        press_nxt = (press_r == '1) ? press_r : press_r + TimW'(1);
      end else begin
        gap_nxt = gap_inc;
        if (gap_inc >= gap_thr_r && !gapdec_r && (count_r != '0 || ovf_r)) begin
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          gapdec_nxt = 1'b1;
          res_valid  = 1'b1;
          if (dec_char != '0) begin
            res_kind = EV_CHAR;
            res_char = dec_char;
          end else begin
            res_kind = EV_UNKNOWN;
          end
        end
      end
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r  <= 1'b0;
      stable_r    <= '0;
      deb_r       <= 1'b0;
      press_r     <= '0;
      gap_r       <= '0;
      sym_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      gapdec_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      raw_prev_r  <= raw_prev_nxt;
      stable_r    <= stable_nxt;
      deb_r       <= deb_nxt;
      press_r     <= press_nxt;
      gap_r       <= gap_nxt;
      sym_r       <= sym_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      gapdec_r    <= gapdec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload is loaded only when a new event is produced.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_kind_r <= res_kind;
      out_char_r <= res_char;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MaxCnt)
    else $error("symbol count exceeds capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == MaxCnt))
    else $error("overflow set while sequence not full");

  a_char_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != EV_CHAR) |-> (out_char_r == '0))
    else $error("character code on a non-character event");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result lost while stalled");

endmodule

`default_nettype wire

// ----- tb/morse_key_decoder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for morse_key_decoder: a table of directed key
// patterns, then randomized keying under several register settings.
// Depends on mkd_pkg and the morse_key_decoder RTL.

module morse_key_decoder_tb;
  import mkd_pkg::*;

  localparam int SEQ_DEPTH = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int FIRST_FAST_ROW = 2;
  localparam int ROW_COUNT = 27;

  typedef struct packed {
    event_kind_t      kind;
    logic [CharW-1:0] chr;
  } key_event_t;

  // One directed row: press for hi_ticks, release for lo_ticks, reps times.
  // When chk is set, the last event of the row must match kind and chr.
  typedef struct packed {
    int unsigned      hi_ticks;
    int unsigned      lo_ticks;
    int unsigned      reps;
    bit               chk;
    event_kind_t      kind;
    logic [CharW-1:0] chr;
  } key_row_t;

  // Rows 0 and 1 run with the register defaults; the rest run with
  // debounce 0, dash 2, long 5, gap 3.
  localparam key_row_t KEY_ROWS [ROW_COUNT] = '{
    '{100, 51, 1, 1'b1, EV_DOT, 7'h00},
    '{0, 1000, 1, 1'b1, EV_CHAR, 7'h65},
    '{1, 1, 1, 1'b1, EV_DOT, 7'h00},
    '{4, 4, 1, 1'b1, EV_CHAR, 7'h61},
    '{3, 4, 1, 1'b1, EV_CHAR, 7'h65},
    '{6, 4, 1, 1'b1, EV_CHAR, 7'h74},
    '{7, 5, 1, 1'b1, EV_CLEAR, 7'h00},
    '{1, 1, 9, 1'b1, EV_DOT, 7'h00},
    '{0, 3, 1, 1'b1, EV_UNKNOWN, 7'h00},
    '{1, 1, 9, 1'b0, EV_DOT, 7'h00},
    '{7, 4, 1, 1'b1, EV_CLEAR, 7'h00},
    '{1, 1, 1, 1'b0, EV_DOT, 7'h00},
    '{4, 1, 1, 1'b0, EV_DOT, 7'h00},
    '{1, 1, 1, 1'b0, EV_DOT, 7'h00},
    '{4, 4, 1, 1'b1, EV_CHAR, 7'h2a},
    '{1, 1, 1, 1'b0, EV_DOT, 7'h00},
    '{4, 1, 1, 1'b0, EV_DOT, 7'h00},
    '{1, 1, 1, 1'b0, EV_DOT, 7'h00},
    '{4, 1, 1, 1'b0, EV_DOT, 7'h00},
    '{1, 4, 1, 1'b1, EV_CHAR, 7'h20},
    '{1, 1, 2, 1'b0, EV_DOT, 7'h00},
    '{4, 1, 2, 1'b0, EV_DOT, 7'h00},
    '{0, 3, 1, 1'b1, EV_UNKNOWN, 7'h00},
    '{1, 1, 4, 1'b0, EV_DOT, 7'h00},
    '{1, 4, 1, 1'b1, EV_UNKNOWN, 7'h00},
    '{1, 1, 5, 1'b0, EV_DOT, 7'h00},
    '{1, 4, 1, 1'b1, EV_UNKNOWN, 7'h00}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_key_level;
  logic                out_valid;
  logic                out_ready;
  logic [KindW-1:0]    out_event_kind;
  logic [CharW-1:0]    out_char_code;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  // Predictor copy of the registers and the decoder state.
  logic [DebW-1:0]      deb_ticks;
  logic [TimW-1:0]      dash_thr;
  logic [TimW-1:0]      long_thr;
  logic [TimW-1:0]      gap_thr;
  logic                 raw_prev;
  logic [DebW-1:0]      stable_cnt;
  logic                 deb_level;
  logic [TimW-1:0]      press_cnt;
  logic [TimW-1:0]      quiet_cnt;
  logic [SEQ_DEPTH-1:0] symbols;
  logic [3:0]           sym_len;
  logic                 overflowed;
  logic                 decoded;

  // Codes of one to four symbols, indexed by (2^len - 2) + code, where the
  // first symbol is the MSB and a dash is 1. A period marks a hole.
  string symbol_tree = "etianmsurwdkgohvf.l*pjbxcyzq..";

  key_event_t events_due[$];
  key_event_t last_event;
  key_event_t head;
  int         events_made;
  int         results_seen;
  int         failures;
  int         keys_sent;
  int         burst_left;
  bit         sender_idles;

  morse_key_decoder #(
    .MAX_SYMBOLS(SEQ_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_level  (in_key_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_kind(out_event_kind),
    .out_char_code (out_char_code),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CharW-1:0] letter_for();
    logic [4:0] code;
    int         idx;
    byte        c;
    code = '0;
    if (overflowed || sym_len == 0 || sym_len > 5) return '0;
    for (int i = 0; i < sym_len; i++) code = {code[3:0], symbols[i]};
    if (sym_len == 5) return (code == 5'd10) ? 7'h20 : 7'h00;
    idx = (1 << sym_len) - 2 + code;
    c = symbol_tree[idx];
    return (c == ".") ? 7'h00 : c[6:0];
  endfunction

  // Advances the predictor by one key sample and queues the event it causes.
  task automatic decode_tick(input logic key);
    key_event_t ev;
    bit         emit;
    logic       sym;
    emit = 1'b0;
    ev.chr = '0;
    ev.kind = EV_DOT;
    if (key != raw_prev) stable_cnt = '0;
    else if (stable_cnt != '1) stable_cnt++;
    raw_prev = key;
    if (stable_cnt >= deb_ticks && key != deb_level) begin
      deb_level = key;
      if (key) begin
        press_cnt = '0;
      end else begin
        quiet_cnt = '0;
        decoded = 1'b0;
        emit = 1'b1;
        if (press_cnt > long_thr) begin
          sym_len = '0;
          overflowed = 1'b0;
          ev.kind = EV_CLEAR;
        end else begin
          sym = press_cnt > dash_thr;
          if (sym_len < SEQ_DEPTH) begin
            symbols[sym_len] = sym;
            sym_len++;
          end else begin
            overflowed = 1'b1;
          end
          ev.kind = sym ? EV_DASH : EV_DOT;
        end
      end
    end else if (deb_level) begin
      if (press_cnt != '1) press_cnt++;
    end else begin
      if (quiet_cnt != '1) quiet_cnt++;
      if (quiet_cnt >= gap_thr && !decoded && (sym_len != 0 || overflowed)) begin
        ev.chr = letter_for();
        ev.kind = (ev.chr != 0) ? EV_CHAR : EV_UNKNOWN;
        sym_len = '0;
        overflowed = 1'b0;
        decoded = 1'b1;
        emit = 1'b1;
      end
    end
    if (emit) begin
      events_due.push_back(ev);
      last_event = ev;
      events_made++;
    end
  endtask

  // Offers one key sample; the sender sometimes pauses between bursts of transfers.
  task automatic send_key(input logic lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (sender_idles && gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_key_level <= lvl;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    keys_sent++;
    decode_tick(lvl);
  endtask

  task automatic send_run(input logic lvl, input int unsigned n);
    repeat (n) send_key(lvl);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 3 * (deb_ticks + 2))) send_key(1'($urandom_range(0, 1)));
  endtask

  // A keyed character: mostly dots and dashes, sometimes a clear, with quiet
  // spells mostly short enough to keep the sequence and a long one at the end.
  task automatic send_word();
    int n;
    int cls;
    int t;
    int lo;
    int span;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
    for (int k = 0; k < n; k++) begin
      cls = $urandom_range(0, 19);
      if (cls < 9) t = $urandom_range(0, dash_thr);
      else if (cls < 18) t = $urandom_range(dash_thr + 1, long_thr);
      else t = long_thr + $urandom_range(1, 4);
      if (t < deb_ticks) t = deb_ticks;
      send_run(1'b1, t + 1);
      span = (gap_thr > 2 * deb_ticks + 1) ? gap_thr - 2 * deb_ticks - 1 : 0;
      lo = deb_ticks + 1 + $urandom_range(0, span);
      if (k == n - 1) lo = deb_ticks + gap_thr + $urandom_range(1, 4);
      else if ($urandom_range(0, 9) == 0) lo = $urandom_range(1, deb_ticks + gap_thr + 4);
      send_run(1'b0, lo);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE: deb_ticks = data[DebW-1:0];
      REG_DASH:     dash_thr = data;
      REG_LONG:     long_thr = data;
      REG_GAP:      gap_thr = data;
      default:      ;
    endcase
  endtask

  // Stops offering samples and waits until every expected event is out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CfgDataW-1:0] deb, input logic [CfgDataW-1:0] dash,
                               input logic [CfgDataW-1:0] lng, input logic [CfgDataW-1:0] gap);
    wait_idle();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DASH, dash);
    write_reg(REG_LONG, lng);
    write_reg(REG_GAP, gap);
    // An index past the register list must leave every register alone.
    write_reg(CfgIdxW'($urandom_range(4, 255)), CfgDataW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (events_due.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d char %h",
                 $time, out_event_kind, out_char_code);
        failures++;
      end else begin
        head = events_due.pop_front();
        if (out_event_kind !== head.kind) begin
          $display("%0t: event kind mismatch, expected %0d, actual %0d",
                   $time, head.kind, out_event_kind);
          failures++;
        end
        if (out_char_code !== head.chr) begin
          $display("%0t: char code mismatch, expected %h, actual %h",
                   $time, head.chr, out_char_code);
          failures++;
        end
      end
    end
  end

  // Receiver: changes its stall pattern now and then, and once holds off for
  // a long stretch so that the block backs up into its input.
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (mode_left % 5 == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int goal;
    int mark;
    logic [CfgDataW-1:0] dash;
    logic [CfgDataW-1:0] lng;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key_level = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_wdata = '0;
    deb_ticks = 10'd50;
    dash_thr = 16'd150;
    long_thr = 16'd500;
    gap_thr = 16'd1000;
    raw_prev = 1'b0;
    stable_cnt = '0;
    deb_level = 1'b0;
    press_cnt = '0;
    quiet_cnt = '0;
    symbols = '0;
    sym_len = '0;
    overflowed = 1'b0;
    decoded = 1'b0;
    events_made = 0;
    results_seen = 0;
    failures = 0;
    keys_sent = 0;
    burst_left = 0;
    sender_idles = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < ROW_COUNT; r++) begin
      if (r == FIRST_FAST_ROW) apply_setting(16'd0, 16'd2, 16'd5, 16'd3);
      mark = events_made;
      repeat (KEY_ROWS[r].reps) begin
        send_run(1'b1, KEY_ROWS[r].hi_ticks);
        send_run(1'b0, KEY_ROWS[r].lo_ticks);
      end
      if (KEY_ROWS[r].chk && (events_made == mark || last_event.kind != KEY_ROWS[r].kind ||
                              last_event.chr != KEY_ROWS[r].chr)) begin
        $display("%0t: row %0d, expected kind %0d char %h, actual kind %0d char %h",
                 $time, r, KEY_ROWS[r].kind, KEY_ROWS[r].chr, last_event.kind, last_event.chr);
        failures++;
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
        // Debounce write with high bits set; long threshold below dash.
        1: apply_setting(16'hFC03, 16'd6, 16'd3, 16'd1);
        default: begin
          dash = CfgDataW'($urandom_range(0, 6));
          lng = ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom_range(0, dash)) :
                                              CfgDataW'(dash + $urandom_range(1, 8));
          apply_setting(CfgDataW'($urandom_range(0, 3)), dash, lng,
                        CfgDataW'($urandom_range(0, 12)));
        end
      endcase
      goal = keys_sent + 50;
      while (keys_sent < goal) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        else send_word();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
